// ===== rtl/core/prqt_pkg.sv =====
// Package for the per-link receive quality tracker.
// Shared types, register indexes and constants; no dependencies.
package prqt_pkg;

	localparam int NUM_RECEIVERS = 8;
	localparam int RID_W = (NUM_RECEIVERS > 1) ? $clog2(NUM_RECEIVERS) : 1;
	localparam int AVG_FRAC_BITS = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EMA_ALPHA = 2'd0,
		REG_MAX_SEQ_GAP = 2'd1,
		REG_ACTIVE_RX = 2'd2,
		REG_NONE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] receiver_id;
		logic crc_ok;
		logic self_type;
		logic [11:0] mac_seq;
		logic [11:0] body_len;
		logic phy_ok;
		logic [7:0] rssi_a;
		logic [7:0] rssi_b;
		logic signed [7:0] snr_a;
		logic signed [7:0] snr_b;
		logic signed [7:0] evm_a;
		logic signed [7:0] evm_b;
	} in_item_t;

	typedef struct packed {
		logic bad_receiver;
		logic self_diverted;
		logic [31:0] expected_count;
		logic [31:0] received_count;
		logic [31:0] crc_fail_count;
		logic [11:0] rssi_avg;
		logic signed [11:0] snr_avg;
		logic signed [11:0] evm_avg;
	} out_item_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic bad;
		logic self_frm;
		logic [RID_W-1:0] rid;
		in_item_t item;
	} cmd_t;

	typedef struct packed {
		logic [7:0] ema_alpha;
		logic [10:0] max_seq_gap;
	} cfg_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// one EMA step on a 12-bit slot; sgn selects signed range
	function automatic logic [11:0] ema_fold(input logic [11:0] old, input logic first,
		input logic sgn, input logic signed [9:0] v, input logic [7:0] alpha);
		logic signed [13:0] s;
		logic signed [13:0] o;
		logic signed [24:0] acc;
		logic signed [16:0] r;
		s = 14'(v) <<< AVG_FRAC_BITS;
		o = sgn ? 14'(signed'(old)) : {2'b00, old};
		acc = 25'(o) * 25'(signed'({1'b0, 9'd256 - {1'b0, alpha}}))
			+ 25'(s) * 25'(signed'({1'b0, alpha})) + 25'sd128;
		r = first ? 17'(s) : 17'(acc >>> 8);
		if (sgn) begin
			if (r < -17'sd2048) return 12'h800;
			if (r > 17'sd2047) return 12'h7FF;
		end else begin
			if (r < 0) return 12'h000;
			if (r > 17'sd4095) return 12'hFFF;
		end
		return r[11:0];
	endfunction

endpackage

// ===== rtl/core/per_link_rx_quality_tracker.sv =====
// Top level: per-link receive quality tracker with config registers.
// Depends on prqt_pkg, prqt_front, prqt_back.
// Path from an accepted report to result valid: queue, record snapshot, output reg.
// The back end takes a new report from the queue only after the previous one has retired its record read-modify-write.
// Reset: async active low clears all counters, marks, averages and queue.
module per_link_rx_quality_tracker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input prqt_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output prqt_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import prqt_pkg::*;

	cfg_t cfg_q;
	logic [3:0] act_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ema_alpha <= 8'd26;
			cfg_q.max_seq_gap <= 11'd512;
			act_q <= 4'd4;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EMA_ALPHA: cfg_q.ema_alpha <= cfg_data[7:0];
				REG_MAX_SEQ_GAP: cfg_q.max_seq_gap <= cfg_data[10:0];
				REG_ACTIVE_RX: act_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	prqt_front u_front (
		.clk, .arst_n, .active_receivers(act_q),
		.in_valid, .in_stall, .in_data,
		.cmd_valid, .cmd_pop, .cmd
	);

	prqt_back u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.cmd_valid, .cmd_pop, .cmd,
		.out_valid, .out_stall, .out_data
	);
endmodule

// ===== rtl/core/prqt_front.sv =====
// Front end: accepts reports, checks receiver range, classifies, queues.
// Depends on prqt_pkg.
module prqt_front (
	input logic clk,
	input logic arst_n,
	input logic [3:0] active_receivers,
	input logic in_valid,
	output logic in_stall,
	input prqt_pkg::in_item_t in_data,
	output logic cmd_valid,
	input logic cmd_pop,
	output prqt_pkg::cmd_t cmd
);
	import prqt_pkg::*;

	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic push, lim_ok;
	cmd_t c;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign lim_ok = ({4'd0, in_data.receiver_id} < 12'(active_receivers))
		&& ({4'd0, in_data.receiver_id} < 12'(NUM_RECEIVERS));

	always_comb begin
		c.bad = !lim_ok;
		c.self_frm = in_data.crc_ok && in_data.self_type;
		c.rid = in_data.receiver_id[RID_W-1:0];
		c.item = in_data;
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (cmd_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= c;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("push lost");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("pop of empty queue");
endmodule

// ===== rtl/core/prqt_back.sv =====
// Back end: read-modify-write of the per-receiver record.
// Depends on prqt_pkg.
module prqt_back (
	input logic clk,
	input logic arst_n,
	input prqt_pkg::cfg_t cfg,
	input logic cmd_valid,
	output logic cmd_pop,
	input prqt_pkg::cmd_t cmd,
	output logic out_valid,
	input logic out_stall,
	output prqt_pkg::out_item_t out_data
);
	import prqt_pkg::*;

	logic [31:0] frame_q [NUM_RECEIVERS];
	logic [39:0] byte_q [NUM_RECEIVERS];
	logic [31:0] crc_q [NUM_RECEIVERS];
	logic [31:0] self_q [NUM_RECEIVERS];
	logic [31:0] exp_q [NUM_RECEIVERS];
	logic [31:0] rcv_q [NUM_RECEIVERS];
	logic [11:0] mark_q [NUM_RECEIVERS];
	logic [NUM_RECEIVERS-1:0] mark_v_q;
	logic [11:0] rf_q [NUM_RECEIVERS][6];
	logic [NUM_RECEIVERS-1:0] rf_v_q;
	logic [11:0] evm_q [NUM_RECEIVERS][3];
	logic [2:0] evm_v_q [NUM_RECEIVERS];
	logic [31:0] bad_cnt_q;

	// stage 1 holds the transaction and the record snapshot
	logic busy_s1;
	cmd_t c_s1;
	logic [31:0] exp_s1, rcv_s1, crc_s1;
	logic [11:0] mark_s1;
	logic mark_v_s1, rf_v_s1;
	logic [2:0] evm_v_s1;
	logic [11:0] rf_s1 [6];
	logic [11:0] evm_s1 [3];

	logic out_full_q;
	out_item_t out_q;
	logic done;

	assign done = busy_s1 && (!out_full_q || !out_stall);
	assign cmd_pop = cmd_valid && !busy_s1;
	assign out_valid = out_full_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			if (cmd_pop) busy_s1 <= 1'b1;
			else if (done) busy_s1 <= 1'b0;
			if (done) out_full_q <= 1'b1;
			else if (!out_stall) out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			c_s1 <= cmd;
			exp_s1 <= exp_q[cmd.rid];
			rcv_s1 <= rcv_q[cmd.rid];
			crc_s1 <= crc_q[cmd.rid];
			mark_s1 <= mark_q[cmd.rid];
			mark_v_s1 <= mark_v_q[cmd.rid];
			rf_v_s1 <= rf_v_q[cmd.rid];
			evm_v_s1 <= evm_v_q[cmd.rid];
			rf_s1 <= rf_q[cmd.rid];
			evm_s1 <= evm_q[cmd.rid];
		end
	end

	// update logic
	logic [11:0] adv;
	logic [31:0] exp_add, exp_n, rcv_n, crc_n;
	logic upd_mark;
	logic [7:0] rmax;
	logic signed [7:0] smax, ebest;
	logic oka, okb, okbest;
	logic [11:0] rf_n [6];
	logic [11:0] evm_n [3];
	logic signed [9:0] rf_in [6];
	logic clean;

	always_comb begin
		clean = !c_s1.bad && !c_s1.self_frm && c_s1.item.crc_ok;
		adv = c_s1.item.mac_seq - mark_s1;
		upd_mark = 1'b0;
		exp_add = 32'd1;
		if (mark_v_s1) begin
			if (adv == 12'd0) exp_add = 32'd1;
			else if (!adv[11]) begin
				exp_add = ({1'b0, adv[10:0]} > {1'b0, cfg.max_seq_gap}) ? 32'd1 : 32'(adv);
				upd_mark = 1'b1;
			end else exp_add = 32'd0;
		end else upd_mark = 1'b1;
		exp_n = clean ? sat_inc32(exp_s1, exp_add) : exp_s1;
		rcv_n = clean ? sat_inc32(rcv_s1, 32'd1) : rcv_s1;
		crc_n = (!c_s1.bad && !c_s1.item.crc_ok) ? sat_inc32(crc_s1, 32'd1) : crc_s1;

		rmax = (c_s1.item.rssi_a > c_s1.item.rssi_b) ? c_s1.item.rssi_a : c_s1.item.rssi_b;
		smax = (c_s1.item.snr_a > c_s1.item.snr_b) ? c_s1.item.snr_a : c_s1.item.snr_b;
		rf_in[0] = 10'({2'b00, rmax});
		rf_in[1] = 10'({2'b00, c_s1.item.rssi_a});
		rf_in[2] = 10'({2'b00, c_s1.item.rssi_b});
		rf_in[3] = 10'(smax);
		rf_in[4] = 10'(c_s1.item.snr_a);
		rf_in[5] = 10'(c_s1.item.snr_b);
		for (int k = 0; k < 6; k++) begin
			rf_n[k] = (clean && c_s1.item.phy_ok)
				? ema_fold(rf_s1[k], !rf_v_s1, k >= 3, rf_in[k], cfg.ema_alpha) : rf_s1[k];
		end

		oka = c_s1.item.evm_a != 8'sd0 && c_s1.item.evm_a != -8'sd128;
		okb = c_s1.item.evm_b != 8'sd0 && c_s1.item.evm_b != -8'sd128;
		ebest = (oka && okb) ? ((c_s1.item.evm_a < c_s1.item.evm_b) ? c_s1.item.evm_a
			: c_s1.item.evm_b) : (oka ? c_s1.item.evm_a : c_s1.item.evm_b);
		okbest = ebest != 8'sd0 && ebest != -8'sd128;
		evm_n[0] = (clean && oka) ? ema_fold(evm_s1[0], !evm_v_s1[0], 1'b1,
			10'(c_s1.item.evm_a), cfg.ema_alpha) : evm_s1[0];
		evm_n[1] = (clean && okb) ? ema_fold(evm_s1[1], !evm_v_s1[1], 1'b1,
			10'(c_s1.item.evm_b), cfg.ema_alpha) : evm_s1[1];
		evm_n[2] = (clean && okbest) ? ema_fold(evm_s1[2], !evm_v_s1[2], 1'b1,
			10'(ebest), cfg.ema_alpha) : evm_s1[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RECEIVERS; i++) begin
				frame_q[i] <= '0; byte_q[i] <= '0; crc_q[i] <= '0; self_q[i] <= '0;
				exp_q[i] <= '0; rcv_q[i] <= '0; mark_q[i] <= '0; evm_v_q[i] <= '0;
				for (int k = 0; k < 6; k++) rf_q[i][k] <= '0;
				for (int k = 0; k < 3; k++) evm_q[i][k] <= '0;
			end
			mark_v_q <= '0;
			rf_v_q <= '0;
			bad_cnt_q <= '0;
		end else if (done) begin
			if (c_s1.bad) begin
				bad_cnt_q <= sat_inc32(bad_cnt_q, 32'd1);
			end else if (c_s1.self_frm) begin
				self_q[c_s1.rid] <= sat_inc32(self_q[c_s1.rid], 32'd1);
			end else begin
				frame_q[c_s1.rid] <= sat_inc32(frame_q[c_s1.rid], 32'd1);
				byte_q[c_s1.rid] <= ({1'b0, byte_q[c_s1.rid]} + 41'(c_s1.item.body_len)
					> 41'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF
					: byte_q[c_s1.rid] + 40'(c_s1.item.body_len);
				crc_q[c_s1.rid] <= crc_n;
				exp_q[c_s1.rid] <= exp_n;
				rcv_q[c_s1.rid] <= rcv_n;
				if (clean) begin
					if (upd_mark) mark_q[c_s1.rid] <= c_s1.item.mac_seq;
					mark_v_q[c_s1.rid] <= 1'b1;
					if (c_s1.item.phy_ok) rf_v_q[c_s1.rid] <= 1'b1;
					evm_v_q[c_s1.rid] <= evm_v_s1 | {okbest, okb, oka};
				end
				rf_q[c_s1.rid] <= rf_n;
				evm_q[c_s1.rid] <= evm_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q.bad_receiver <= c_s1.bad;
			out_q.self_diverted <= !c_s1.bad && c_s1.self_frm;
			out_q.expected_count <= c_s1.bad ? '0 : exp_n;
			out_q.received_count <= c_s1.bad ? '0 : rcv_n;
			out_q.crc_fail_count <= c_s1.bad ? '0 : crc_n;
			out_q.rssi_avg <= c_s1.bad ? '0 : rf_n[0];
			out_q.snr_avg <= c_s1.bad ? '0 : rf_n[3];
			out_q.evm_avg <= c_s1.bad ? '0 : evm_n[2];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy_s1)
		else $error("retire without transaction");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_full_q && out_stall) |=> $stable(out_q))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && c_s1.bad) |-> !clean)
		else $error("bad receiver touched record");
endmodule
